// ===== hw/rtl/dbw_pkg.sv =====
// shared types, codes and defaults for the depth/breadth-first worklist
`timescale 1ns / 1ps

package dbw_pkg;

  localparam int unsigned LIST_DEPTH_DEFAULT = 64;
  localparam int unsigned ID_WIDTH_DEFAULT   = 16;

  // configuration register byte addresses
  localparam logic [2:0] CFG_ORDER_MODE_ADDR = 3'd0;

  // order mode values
  localparam logic MODE_DEPTH_FIRST   = 1'b0;
  localparam logic MODE_BREADTH_FIRST = 1'b1;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_MOVE   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_FOUND = 2'd1,
    ERR_FULL      = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_NEXT,
    RD_BACK,
    RD_FRONT
  } rd_sel_e;

  typedef enum logic {
    WR_ID_AT_CNT,
    WR_RDATA_AT_PTR
  } wr_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHK_BACK,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_SEL_RD,
    ST_SEL_WAIT,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    latch_in;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    err_set;
    err_e    err_code;
    logic    sel_clr;
    logic    sel_load;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_e func;
    logic  mode;
    logic  full;
    logic  cnt_zero;
    logic  ptr_done;
    logic  shift_more;
    logic  hit;
  } dp_status_t;

endpackage

// ===== hw/rtl/dfs_bfs_worklist.sv =====
// top level of the depth/breadth-first worklist
`timescale 1ns / 1ps

// ordered worklist of state ids with depth-first or breadth-first selection
// input channel: in_valid_i / in_stall_o carry one word of func_i and state_id_i;
//   func add appends at the back, remove drops one matching id and closes the
//   gap, move takes the oldest matching id to the back
// output channel: out_valid_o / out_stall_i carry one result word per input
//   word: selected_id_o, entry_count_o, list_empty_o, event_error_o
// config: apb port, order_mode at byte address 0 (0 newest, 1 oldest);
//   write it only while the block is idle
// sequence: one word is worked on at a time; an add or an unknown func decodes,
//   then reads the selected slot and loads the result (the read is skipped when
//   the list ends empty); remove and move scan the slot memory from the front,
//   a read and a compare per slot, then close the gap with a read and a write
//   per slot shifted; the next word can be taken in the cycle after the result
//   loads; the single port pair of the slot memory sets this slot-by-slot pace
// a depth-first remove that hits the newest entry skips the scan
// reset clears the count, the mode and the handshake state; slot contents
//   need no clearing since only held slots are read
// a stalled receiver holds the result register; the next word is still
//   taken and worked on, and its result waits until the register frees
module dfs_bfs_worklist #(
  parameter int unsigned LIST_DEPTH = dbw_pkg::LIST_DEPTH_DEFAULT,
  parameter int unsigned ID_WIDTH   = dbw_pkg::ID_WIDTH_DEFAULT,
  localparam int unsigned CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // event input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [ID_WIDTH-1:0] state_id_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ID_WIDTH-1:0] selected_id_o,
  output logic [CNT_W-1:0]    entry_count_o,
  output logic                list_empty_o,
  output logic [1:0]          event_error_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  dbw_pkg::dp_cmd_t    cmd;
  dbw_pkg::dp_status_t status;
  logic                cfg_we;
  logic                mode;

  // only the word-aligned register slot decodes; the low address bits are don't care
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[2] == dbw_pkg::CFG_ORDER_MODE_ADDR[2]);
  assign prdata = (paddr[2] == dbw_pkg::CFG_ORDER_MODE_ADDR[2]) ? {31'b0, mode} : 32'b0;

  dbw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dbw_datapath #(
    .LIST_DEPTH (LIST_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (func_i),
    .state_id_i    (state_id_i),
    .cfg_we_i      (cfg_we),
    .cfg_mode_i    (pwdata[0]),
    .mode_o        (mode),
    .cmd_i         (cmd),
    .status_o      (status),
    .selected_id_o (selected_id_o),
    .entry_count_o (entry_count_o),
    .list_empty_o  (list_empty_o),
    .event_error_o (event_error_o)
  );

endmodule

// ===== hw/rtl/dbw_datapath.sv =====
// worklist storage, pointers, compare and result registers
`timescale 1ns / 1ps

module dbw_datapath #(
  parameter int unsigned LIST_DEPTH = dbw_pkg::LIST_DEPTH_DEFAULT,
  parameter int unsigned ID_WIDTH   = dbw_pkg::ID_WIDTH_DEFAULT,
  localparam int unsigned AW        = $clog2(LIST_DEPTH),
  localparam int unsigned CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          func_i,
  input  logic [ID_WIDTH-1:0] state_id_i,
  input  logic                cfg_we_i,
  input  logic                cfg_mode_i,
  output logic                mode_o,
  input  dbw_pkg::dp_cmd_t    cmd_i,
  output dbw_pkg::dp_status_t status_o,
  output logic [ID_WIDTH-1:0] selected_id_o,
  output logic [CNT_W-1:0]    entry_count_o,
  output logic                list_empty_o,
  output logic [1:0]          event_error_o
);

  logic [ID_WIDTH-1:0] mem_q [LIST_DEPTH];
  logic [ID_WIDTH-1:0] rdata_q;
  logic [1:0]          func_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    ptr_inc;
  logic [CNT_W-1:0]    cnt_dec;
  logic                mode_q;
  dbw_pkg::err_e       err_q;
  logic [ID_WIDTH-1:0] sel_q;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [ID_WIDTH-1:0] wdata;

  logic [ID_WIDTH-1:0] out_sel_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic                out_empty_q;
  logic [1:0]          out_err_q;

  assign ptr_inc = ptr_q + CNT_W'(1);
  assign cnt_dec = cnt_q - CNT_W'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      dbw_pkg::RD_PTR:      raddr = ptr_q[AW-1:0];
      dbw_pkg::RD_PTR_NEXT: raddr = ptr_inc[AW-1:0];
      dbw_pkg::RD_BACK:     raddr = cnt_dec[AW-1:0];
      dbw_pkg::RD_FRONT:    raddr = '0;
      default:              raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      dbw_pkg::WR_ID_AT_CNT: begin
        waddr = cnt_q[AW-1:0];
        wdata = id_q;
      end
      dbw_pkg::WR_RDATA_AT_PTR: begin
        waddr = ptr_q[AW-1:0];
        wdata = rdata_q;
      end
      default: begin
        waddr = '0;
        wdata = id_q;
      end
    endcase
  end

  // slot storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_dec;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ptr_q  <= '0;
      mode_q <= dbw_pkg::MODE_DEPTH_FIRST;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= func_i;
      id_q   <= state_id_i;
      err_q  <= dbw_pkg::ERR_NONE;
    end else if (cmd_i.err_set) begin
      err_q <= cmd_i.err_code;
    end
    if (cmd_i.sel_clr) begin
      sel_q <= '0;
    end else if (cmd_i.sel_load) begin
      sel_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_sel_q   <= sel_q;
      out_cnt_q   <= cnt_q;
      out_empty_q <= (cnt_q == '0);
      out_err_q   <= err_q;
    end
  end

  always_comb begin
    status_o.func       = dbw_pkg::func_e'(func_q);
    status_o.mode       = mode_q;
    status_o.full       = (cnt_q == CNT_W'(LIST_DEPTH));
    status_o.cnt_zero   = (cnt_q == '0);
    status_o.ptr_done   = (ptr_q >= cnt_q);
    status_o.shift_more = (ptr_inc < cnt_q);
    status_o.hit        = (rdata_q == id_q);
  end

  assign mode_o        = mode_q;
  assign selected_id_o = out_sel_q;
  assign entry_count_o = out_cnt_q;
  assign list_empty_o  = out_empty_q;
  assign event_error_o = out_err_q;

endmodule

// ===== hw/rtl/dbw_ctrl.sv =====
// event sequencer and result handshake for the worklist
`timescale 1ns / 1ps

module dbw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  dbw_pkg::dp_status_t status_i,
  output dbw_pkg::dp_cmd_t    cmd_o
);

  dbw_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dbw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.rd_sel   = dbw_pkg::RD_PTR;
    cmd_o.wr_sel   = dbw_pkg::WR_ID_AT_CNT;
    cmd_o.err_code = dbw_pkg::ERR_NONE;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dbw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = dbw_pkg::ST_DECODE;
        end
      end
      dbw_pkg::ST_DECODE: begin
        case (status_i.func)
          dbw_pkg::FUNC_ADD: begin
            if (status_i.full) begin
              cmd_o.err_set  = 1'b1;
              cmd_o.err_code = dbw_pkg::ERR_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = dbw_pkg::WR_ID_AT_CNT;
              cmd_o.cnt_inc = 1'b1;
            end
            state_d = dbw_pkg::ST_SEL_RD;
          end
          dbw_pkg::FUNC_REMOVE: begin
            // depth-first removal prefers the newest entry
            if (status_i.mode == dbw_pkg::MODE_DEPTH_FIRST && !status_i.cnt_zero) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = dbw_pkg::RD_BACK;
              state_d = dbw_pkg::ST_CHK_BACK;
            end else begin
              cmd_o.ptr_clr = 1'b1;
              state_d = dbw_pkg::ST_SCAN_RD;
            end
          end
          dbw_pkg::FUNC_MOVE: begin
            cmd_o.ptr_clr = 1'b1;
            state_d = dbw_pkg::ST_SCAN_RD;
          end
          default: begin
            state_d = dbw_pkg::ST_SEL_RD;
          end
        endcase
      end
      dbw_pkg::ST_CHK_BACK: begin
        if (status_i.hit) begin
          cmd_o.cnt_dec = 1'b1;
          state_d = dbw_pkg::ST_SEL_RD;
        end else begin
          cmd_o.ptr_clr = 1'b1;
          state_d = dbw_pkg::ST_SCAN_RD;
        end
      end
      dbw_pkg::ST_SCAN_RD: begin
        if (status_i.ptr_done) begin
          cmd_o.err_set  = 1'b1;
          cmd_o.err_code = dbw_pkg::ERR_NOT_FOUND;
          state_d = dbw_pkg::ST_SEL_RD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = dbw_pkg::RD_PTR;
          state_d = dbw_pkg::ST_SCAN_CMP;
        end
      end
      dbw_pkg::ST_SCAN_CMP: begin
        if (status_i.hit) begin
          state_d = dbw_pkg::ST_SHIFT_RD;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d = dbw_pkg::ST_SCAN_RD;
        end
      end
      dbw_pkg::ST_SHIFT_RD: begin
        if (status_i.shift_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = dbw_pkg::RD_PTR_NEXT;
          state_d = dbw_pkg::ST_SHIFT_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          if (status_i.func == dbw_pkg::FUNC_MOVE) begin
            state_d = dbw_pkg::ST_APPEND;
          end else begin
            state_d = dbw_pkg::ST_SEL_RD;
          end
        end
      end
      dbw_pkg::ST_SHIFT_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = dbw_pkg::WR_RDATA_AT_PTR;
        cmd_o.ptr_inc = 1'b1;
        state_d = dbw_pkg::ST_SHIFT_RD;
      end
      dbw_pkg::ST_APPEND: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = dbw_pkg::WR_ID_AT_CNT;
        cmd_o.cnt_inc = 1'b1;
        state_d = dbw_pkg::ST_SEL_RD;
      end
      dbw_pkg::ST_SEL_RD: begin
        if (status_i.cnt_zero) begin
          cmd_o.sel_clr = 1'b1;
          state_d = dbw_pkg::ST_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = (status_i.mode == dbw_pkg::MODE_BREADTH_FIRST) ?
                         dbw_pkg::RD_FRONT : dbw_pkg::RD_BACK;
          state_d = dbw_pkg::ST_SEL_WAIT;
        end
      end
      dbw_pkg::ST_SEL_WAIT: begin
        cmd_o.sel_load = 1'b1;
        state_d = dbw_pkg::ST_DONE;
      end
      dbw_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = dbw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dbw_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != dbw_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/dbw_checker.sv =====
// port-level checks for the worklist, bound to the top level
`timescale 1ns / 1ps

module dbw_checker #(
  parameter int unsigned LIST_DEPTH = dbw_pkg::LIST_DEPTH_DEFAULT,
  parameter int unsigned ID_WIDTH   = dbw_pkg::ID_WIDTH_DEFAULT,
  localparam int unsigned CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [ID_WIDTH-1:0] selected_id_o,
  input logic [CNT_W-1:0]    entry_count_o,
  input logic                list_empty_o,
  input logic [1:0]          event_error_o
);

  // empty flag agrees with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (list_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  // an empty list reports id zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && list_empty_o) |-> (selected_id_o == '0))
    else $error("nonzero id on empty list");

  // a full error only happens with the list at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_error_o == dbw_pkg::ERR_FULL) |->
      (entry_count_o == CNT_W'(LIST_DEPTH)))
    else $error("full error with free slots");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(selected_id_o) && $stable(entry_count_o) &&
       $stable(event_error_o)))
    else $error("stalled result changed");

endmodule

bind dfs_bfs_worklist dbw_checker #(
  .LIST_DEPTH (LIST_DEPTH),
  .ID_WIDTH   (ID_WIDTH)
) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .selected_id_o (selected_id_o),
  .entry_count_o (entry_count_o),
  .list_empty_o  (list_empty_o),
  .event_error_o (event_error_o)
);
